@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the scalar Kalman smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define SKC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define SKC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/skc_pkg.sv @@
// Package for the scalar Kalman smoother: widths, codes, control word and microcode table.
`timescale 1ns / 1ps
`default_nettype none

package skc_pkg;

  // Number formats. The estimate is signed Q(SAMPLE_WIDTH).FRAC_BITS, the gain is Q0.FRAC_BITS.
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 24;
  localparam int EST_W        = SAMPLE_WIDTH + FRAC_BITS;
  localparam int VAR_W        = 32;
  localparam int QN_W         = 25;
  localparam int RN_W         = 29;
  localparam int DEN_W        = VAR_W + 1;
  localparam int GAIN_W       = FRAC_BITS;
  localparam int MUL_A_W      = VAR_W;
  localparam int MUL_B_W      = FRAC_BITS + 1;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int CNT_W        = $clog2(FRAC_BITS + 1);
  localparam int UPC_W        = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [QN_W-1:0]  QN_RESET  = QN_W'(1678);
  localparam logic [RN_W-1:0]  RN_RESET  = RN_W'(83886);
  localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'(167772160);

  localparam logic [MUL_B_W-1:0] ONE_F  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [EST_W-1:0]   HALF_F = EST_W'(1) << (FRAC_BITS - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE    = 2'd0,
    REG_MEASURE_NOISE    = 2'd1,
    REG_INITIAL_VARIANCE = 2'd2
  } reg_idx_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_HI,
    MUL_LO,
    MUL_VAR
  } mul_sel_t;

  // Jump conditions of the sequencer.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  // Program addresses.
  localparam upc_t UPC_ACCEPT  = 3'd0;
  localparam upc_t UPC_INIT    = 3'd1;
  localparam upc_t UPC_DIV     = 3'd2;
  localparam upc_t UPC_MUL_HI  = 3'd3;
  localparam upc_t UPC_MUL_LO  = 3'd4;
  localparam upc_t UPC_MUL_VAR = 3'd5;
  localparam upc_t UPC_UPDATE  = 3'd6;
  localparam upc_t UPC_OUTPUT  = 3'd7;

  // One control word: datapath strobes plus the jump condition and target.
  typedef struct packed {
    logic     accept;
    logic     div_init;
    logic     div_step;
    mul_sel_t mul_sel;
    logic     acc_ld;
    logic     step_ld;
    logic     est_upd;
    logic     out_ld;
    cond_t    cond;
    upc_t     target;
  } uword_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic out_busy;
  } stat_t;

  // The microcode table. A step whose condition is false falls through to the next address;
  // the output step falls through to address zero by wrapping.
  function automatic uword_t ucode(input upc_t upc);
    uword_t w;
    w = '0;
    unique case (upc)
      UPC_ACCEPT: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = UPC_ACCEPT;
      end
      UPC_INIT: begin
        w.div_init = 1'b1;
      end
      UPC_DIV: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_MORE;
        w.target   = UPC_DIV;
      end
      UPC_MUL_HI: begin
        w.mul_sel = MUL_HI;
      end
      UPC_MUL_LO: begin
        w.mul_sel = MUL_LO;
        w.acc_ld  = 1'b1;
      end
      UPC_MUL_VAR: begin
        w.mul_sel = MUL_VAR;
        w.step_ld = 1'b1;
      end
      UPC_UPDATE: begin
        w.est_upd = 1'b1;
      end
      UPC_OUTPUT: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = UPC_OUTPUT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/skc_sequencer.sv @@
// Microcode sequencer: program counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module skc_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire skc_pkg::stat_t stat,
  output skc_pkg::uword_t     ctrl
);

  skc_pkg::upc_t pc;
  skc_pkg::upc_t pc_next;
  logic          take;

  assign ctrl = skc_pkg::ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      skc_pkg::COND_NONE:     take = 1'b0;
      skc_pkg::COND_NO_INPUT: take = !stat.in_fire;
      skc_pkg::COND_DIV_MORE: take = !stat.div_last;
      skc_pkg::COND_OUT_BUSY: take = stat.out_busy;
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + skc_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= skc_pkg::UPC_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  `SKC_ASSERT_NXT(a_accept_starts_item, clk, rst, stat.in_fire, pc == skc_pkg::UPC_INIT, "accepted sample did not start the program")
  `SKC_ASSERT_NXT(a_output_returns, clk, rst, (pc == skc_pkg::UPC_OUTPUT) && !stat.out_busy, pc == skc_pkg::UPC_ACCEPT, "sequencer did not return to accept after output")

endmodule

`default_nettype wire

@@ hw/rtl/skc_datapath.sv @@
// Datapath: configuration registers, filter state, serial divider, shared multiplier, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module skc_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire skc_pkg::uword_t                       ctrl,
  output skc_pkg::stat_t                             stat,
  input  wire logic                                  cfg_valid,
  input  wire logic [skc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [skc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                  in_valid,
  input  wire logic signed [skc_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic signed [skc_pkg::SAMPLE_WIDTH-1:0]    out_filtered
);

  logic [skc_pkg::QN_W-1:0]         process_noise;
  logic [skc_pkg::RN_W-1:0]         measure_noise;
  logic [skc_pkg::VAR_W-1:0]        variance;
  logic [skc_pkg::EST_W-1:0]        estimate;
  logic [skc_pkg::SAMPLE_WIDTH-1:0] sample;

  logic [skc_pkg::DEN_W-1:0]  den;
  logic [skc_pkg::DEN_W-1:0]  rem;
  logic [skc_pkg::GAIN_W-1:0] gain;
  logic [skc_pkg::CNT_W-1:0]  cnt;

  logic                        neg;
  logic [skc_pkg::EST_W-1:0]   mag;
  logic [skc_pkg::PROD_W-1:0]  prod;
  logic [skc_pkg::EST_W-1:0]   acc;
  logic [skc_pkg::EST_W-1:0]   stepv;

  logic                         in_fire;
  logic                         out_busy;
  logic                         var_cfg;
  logic [skc_pkg::DEN_W-1:0]    vsum;
  logic [skc_pkg::RN_W-1:0]     r_eff;
  logic [skc_pkg::EST_W:0]      diff;
  logic [skc_pkg::DEN_W:0]      rem2;
  logic                         ge;
  logic [skc_pkg::MUL_A_W-1:0]  mul_a;
  logic [skc_pkg::MUL_B_W-1:0]  mul_b;
  logic [2*skc_pkg::FRAC_BITS:0] lo_sum;
  logic [skc_pkg::EST_W-1:0]    rnd;

  assign in_fire  = in_valid && ctrl.accept;
  assign out_busy = out_valid && !out_ready;
  assign var_cfg  = cfg_valid && (cfg_index == skc_pkg::REG_INITIAL_VARIANCE);

  assign stat.in_fire  = in_fire;
  assign stat.div_last = (cnt == skc_pkg::CNT_W'(skc_pkg::FRAC_BITS - 1));
  assign stat.out_busy = out_busy;

  // Variance growth by q, saturating at the top of the word.
  assign vsum  = {1'b0, variance} + skc_pkg::DEN_W'(process_noise);
  assign r_eff = (measure_noise == '0) ? skc_pkg::RN_W'(1) : measure_noise;

  // Distance from the estimate to the sample, as sign and magnitude.
  assign diff = {sample[skc_pkg::SAMPLE_WIDTH-1], sample, {skc_pkg::FRAC_BITS{1'b0}}}
              - {estimate[skc_pkg::EST_W-1], estimate};

  // One restoring division step: the remainder always stays below the denominator.
  assign rem2 = {rem, 1'b0};
  assign ge   = (rem2 >= {1'b0, den});

  always_comb begin
    unique case (ctrl.mul_sel)
      skc_pkg::MUL_HI: begin
        mul_a = skc_pkg::MUL_A_W'(mag[skc_pkg::EST_W-1:skc_pkg::FRAC_BITS]);
        mul_b = skc_pkg::MUL_B_W'(gain);
      end
      skc_pkg::MUL_LO: begin
        mul_a = skc_pkg::MUL_A_W'(mag[skc_pkg::FRAC_BITS-1:0]);
        mul_b = skc_pkg::MUL_B_W'(gain);
      end
      skc_pkg::MUL_VAR: begin
        mul_a = variance;
        mul_b = skc_pkg::ONE_F - skc_pkg::MUL_B_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Low partial product rounded to nearest at the binary point.
  assign lo_sum = prod[2*skc_pkg::FRAC_BITS:0]
                + (2*skc_pkg::FRAC_BITS+1)'(skc_pkg::HALF_F);
  assign rnd    = estimate + skc_pkg::HALF_F;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= skc_pkg::QN_RESET;
      measure_noise <= skc_pkg::RN_RESET;
      variance      <= skc_pkg::VAR_RESET;
      estimate      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == skc_pkg::REG_PROCESS_NOISE)) begin
        process_noise <= cfg_data[skc_pkg::QN_W-1:0];
      end
      if (cfg_valid && (cfg_index == skc_pkg::REG_MEASURE_NOISE)) begin
        measure_noise <= cfg_data[skc_pkg::RN_W-1:0];
      end

      if (var_cfg) begin
        variance <= cfg_data[skc_pkg::VAR_W-1:0];
        estimate <= '0;
      end else if (in_fire) begin
        variance <= vsum[skc_pkg::VAR_W] ? '1 : vsum[skc_pkg::VAR_W-1:0];
      end else if (ctrl.est_upd) begin
        variance <= prod[skc_pkg::FRAC_BITS+skc_pkg::VAR_W-1:skc_pkg::FRAC_BITS];
        estimate <= neg ? (estimate - stepv) : (estimate + stepv);
      end

      if (ctrl.out_ld && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample <= in_sample;
    end
    if (ctrl.div_init) begin
      den  <= skc_pkg::DEN_W'(variance) + skc_pkg::DEN_W'(r_eff);
      rem  <= skc_pkg::DEN_W'(variance);
      cnt  <= '0;
      neg  <= diff[skc_pkg::EST_W];
      mag  <= diff[skc_pkg::EST_W] ? skc_pkg::EST_W'(-diff) : diff[skc_pkg::EST_W-1:0];
    end
    if (ctrl.div_step) begin
      rem  <= ge ? skc_pkg::DEN_W'(rem2 - {1'b0, den}) : rem2[skc_pkg::DEN_W-1:0];
      gain <= {gain[skc_pkg::GAIN_W-2:0], ge};
      cnt  <= cnt + skc_pkg::CNT_W'(1);
    end
    if (ctrl.mul_sel != skc_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.acc_ld) begin
      acc <= prod[skc_pkg::EST_W-1:0];
    end
    if (ctrl.step_ld) begin
      stepv <= acc + skc_pkg::EST_W'(lo_sum[2*skc_pkg::FRAC_BITS:skc_pkg::FRAC_BITS]);
    end
    if (ctrl.out_ld && !out_busy) begin
      out_filtered <= rnd[skc_pkg::EST_W-1:skc_pkg::FRAC_BITS];
    end
  end

  `SKC_ASSERT_NXT(a_rem_below_den, clk, rst, ctrl.div_step, rem < den, "divider remainder reached the denominator")
  `SKC_ASSERT_NXT(a_var_shrinks, clk, rst, ctrl.est_upd && !var_cfg, variance <= $past(variance), "variance grew in the update step")
  `SKC_ASSERT_NXT(a_out_held, clk, rst, out_busy, out_valid && $stable(out_filtered), "pending result was overwritten")

endmodule

`default_nettype wire

@@ hw/rtl/scalar_kalman_smoother_core.sv @@
// Top level of the scalar Kalman smoother: stream ports, configuration port, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Scalar Kalman smoother with a constant-state model. Each signed 16-bit sample beat on the
// slave stream updates the estimate (signed Q16.24) and its error variance (unsigned Q8.24)
// and produces one beat on the master stream: the estimate rounded to the nearest integer,
// with ties toward plus infinity. Per sample the variance grows by the process noise with
// saturation, the gain p/(p+r) is formed by a restoring divider, the estimate moves toward
// the sample by gain times the difference, and the variance is scaled by one minus the gain.
// A short microprogram steps one shared datapath through this work: an accept step, a setup
// step, divider iterations that each produce one gain bit, multiply steps and an update step
// that share a single 32x25 multiplier for the estimate and variance updates, and an output
// step. The next sample is taken as soon as the program returns to its first step, even while
// the previous result still waits in the output register; the program only waits at its
// output step if that register is still full. Configuration writes are always accepted and
// should be issued only while the block is idle. Register 0 is the process noise, register 1
// the measurement noise (zero acts as one), and register 2 the initial variance; writing
// register 2 loads the variance and clears the estimate, restarting the filter. Writes to
// index 3 are ignored.

module scalar_kalman_smoother_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // Slave stream: tdata holds sample (bits 15:0).
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic signed [skc_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,
  // Master stream: tdata holds filtered (bits 15:0).
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  output logic signed [skc_pkg::SAMPLE_WIDTH-1:0]      m_axis_tdata,
  // Configuration write channel.
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [skc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [skc_pkg::CFG_DATA_W-1:0]          cfg_data
);

  skc_pkg::uword_t ctrl;
  skc_pkg::stat_t  stat;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  // Samples are taken only at the first step of the program.
  assign s_axis_tready = ctrl.accept;

  skc_sequencer u_sequencer (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  skc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_sample    (s_axis_tdata),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_filtered (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the scalar Kalman smoother core with a bit-exact predictor.
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLE_WIDTH = skc_pkg::SAMPLE_WIDTH;
  localparam int FRAC_BITS    = skc_pkg::FRAC_BITS;
  localparam int QN_W         = skc_pkg::QN_W;
  localparam int RN_W         = skc_pkg::RN_W;
  localparam int VAR_W        = skc_pkg::VAR_W;
  localparam int CFG_IDX_W    = skc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = skc_pkg::CFG_DATA_W;

  // Quiet cycles (no beat on any channel) before the run is declared hung. Both sender gaps and
  // receiver stalls are short geometric runs, so this is many times the slowest legal stretch.
  localparam int STALL_LIMIT   = 2000;
  // Cycles to let pass after the last result before reconfiguring or ending.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 160;

  localparam int S_MAX = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int S_MIN = -(2 ** (SAMPLE_WIDTH - 1));

  // Index 3 is outside the register map; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE = 2'd3;
  localparam logic [CFG_DATA_W-1:0] VAR_FULL  = 32'hFFFF_FFFF;

  // Holds the filter state as the block should see it and the queue of expected estimates.
  class kalman_scoreboard;
    bit [QN_W-1:0]                  q_noise;
    bit [RN_W-1:0]                  r_noise;
    bit [VAR_W-1:0]                 init_var;
    longint                         est;
    bit [63:0]                      p_var;
    logic signed [SAMPLE_WIDTH-1:0] filtered_q[$];
    int                             errors;

    function new();
      q_noise  = skc_pkg::QN_RESET;
      r_noise  = skc_pkg::RN_RESET;
      init_var = skc_pkg::VAR_RESET;
      est      = 0;
      p_var    = skc_pkg::VAR_RESET;
      errors   = 0;
    endfunction

    // mag * g / 2^F rounded to nearest, split so that no product leaves 64 bits.
    function bit [63:0] scaled_step(bit [63:0] mag, bit [63:0] g);
      bit [63:0] frac_mask;
      bit [63:0] half;
      frac_mask = (64'd1 << FRAC_BITS) - 1;
      half      = 64'd1 << (FRAC_BITS - 1);
      return (mag >> FRAC_BITS) * g + (((mag & frac_mask) * g + half) >> FRAC_BITS);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        skc_pkg::REG_PROCESS_NOISE:    q_noise = data[QN_W-1:0];
        skc_pkg::REG_MEASURE_NOISE:    r_noise = data[RN_W-1:0];
        skc_pkg::REG_INITIAL_VARIANCE: begin
          // Loading the initial variance restarts the filter.
          init_var = data;
          p_var    = data;
          est      = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_WIDTH-1:0] s);
      longint    smp;
      longint    diff;
      bit [63:0] r_eff;
      bit [63:0] gain;
      bit [63:0] one_f;
      one_f = 64'd1 << FRAC_BITS;
      smp   = s;
      p_var = p_var + q_noise;
      if (p_var > 64'hFFFF_FFFF) p_var = 64'hFFFF_FFFF;
      r_eff = (r_noise == 0) ? 64'd1 : 64'(r_noise);
      gain  = (p_var << FRAC_BITS) / (p_var + r_eff);
      diff  = (smp <<< FRAC_BITS) - est;
      // The step is rounded on its magnitude, which gives ties away from zero.
      if (diff >= 0) est = est + longint'(scaled_step(diff, gain));
      else est = est - longint'(scaled_step(-diff, gain));
      p_var = (p_var * (one_f - gain)) >> FRAC_BITS;
      // Adding one half and flooring rounds ties toward plus infinity.
      filtered_q.push_back(SAMPLE_WIDTH'((est + (longint'(1) <<< (FRAC_BITS - 1)))
                                         >>> FRAC_BITS));
    endfunction

    task flag(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_filtered(logic signed [SAMPLE_WIDTH-1:0] got);
      logic signed [SAMPLE_WIDTH-1:0] want;
      if (filtered_q.size() == 0) begin
        flag($sformatf("filtered beat %0d with no sample outstanding", got));
      end else begin
        want = filtered_q.pop_front();
        if (got !== want) flag($sformatf("filtered %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic signed [SAMPLE_WIDTH-1:0] s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data = '0;

  kalman_scoreboard sb = new();

  int stall_pct    = 0;
  int quiet_cycles = 0;
  int level        = 0;

  // Directed runs: full-scale swings at reset settings, the same under a saturated variance
  // with zero measurement noise, and a dead filter whose gain is zero.
  logic signed [SAMPLE_WIDTH-1:0] reset_run [10] =
    '{32767, -32768, 0, -1, 1, 32767, 32767, -32768, -32768, 100};
  logic signed [SAMPLE_WIDTH-1:0] saturated_run [6] = '{32767, -32768, 5, -5, 32767, -32768};
  logic signed [SAMPLE_WIDTH-1:0] frozen_run [3] = '{-32768, 32767, 7};

  scalar_kalman_smoother_core DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every beat is picked up at the rising edge it completes on. Config writes and samples go
  // to the predictor in the order the block takes them.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_filtered(m_axis_tdata);
    end
  end

  // The receiver holds off at random, at the rate the current phase asks for.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Holds one register write until the block takes it; valid stays up for a following write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Offers one sample beat. Before the offer the sender idles cycle by cycle at the rate the
  // phase asks for.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] v, input int gap_pct);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Waits for every outstanding estimate, then lets the block settle.
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly a level with small or moderate noise around it, the signal a filter sees in use;
  // the rest are level jumps, full-range noise and full-scale samples.
  function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample();
    int pick;
    int amp;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      amp = (pick < 40) ? 3 : 400;
      v   = level + int'($urandom_range(0, 2 * amp)) - amp;
    end else if (pick < 80) begin
      level = int'($urandom_range(0, 2 * S_MAX + 1)) + S_MIN;
      v     = level;
    end else if (pick < 90) begin
      v = int'($urandom_range(0, 2 * S_MAX + 1)) + S_MIN;
    end else begin
      v = $urandom_range(0, 1) ? S_MAX : S_MIN;
    end
    if (v > S_MAX) v = S_MAX;
    if (v < S_MIN) v = S_MIN;
    return SAMPLE_WIDTH'(v);
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] value;
    logic [CFG_DATA_W-1:0] data;
    int                    gap_pct;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, no idling.
    foreach (reset_run[i]) send_sample(reset_run[i], 0);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // A process noise of 1.0, zero measurement noise and the largest variance: the variance
    // growth saturates and the gain sits just below one.
    cfg_write(skc_pkg::REG_PROCESS_NOISE, 32'd16777216);
    cfg_write(skc_pkg::REG_MEASURE_NOISE, 32'd0);
    cfg_write(skc_pkg::REG_INITIAL_VARIANCE, VAR_FULL);
    cfg_valid <= 1'b0;
    foreach (saturated_run[i]) send_sample(saturated_run[i], 0);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // No process noise and no initial variance: the gain stays zero and the estimate with it.
    // The write to the spare index must change nothing.
    cfg_write(skc_pkg::REG_PROCESS_NOISE, 32'd0);
    cfg_write(skc_pkg::REG_MEASURE_NOISE, 32'h1FFF_FFFF);
    cfg_write(skc_pkg::REG_INITIAL_VARIANCE, 32'd0);
    cfg_write(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    foreach (frozen_run[i]) send_sample(frozen_run[i], 0);
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();

      // Process noise; half the writes carry junk above the register width.
      case ($urandom_range(0, 4))
        0:       value = 32'd0;
        1:       value = 32'd16777216;
        2:       value = $urandom_range(0, 4000);
        3:       value = $urandom_range(0, 200000);
        default: value = $urandom & 32'h01FF_FFFF;
      endcase
      data = $urandom;
      data[QN_W-1:0] = value[QN_W-1:0];
      cfg_write(skc_pkg::REG_PROCESS_NOISE, $urandom_range(0, 1) ? value : data);

      // Measurement noise, zero included.
      case ($urandom_range(0, 5))
        0:       value = 32'd0;
        1:       value = 32'd1;
        2:       value = 32'd268435456;
        3:       value = 32'h1FFF_FFFF;
        4:       value = $urandom_range(1, 200000);
        default: value = $urandom & 32'h1FFF_FFFF;
      endcase
      data = $urandom;
      data[RN_W-1:0] = value[RN_W-1:0];
      cfg_write(skc_pkg::REG_MEASURE_NOISE, $urandom_range(0, 1) ? value : data);

      // Most phases restart the filter; the others carry the state over.
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0:       value = VAR_FULL;
          1:       value = 32'd0;
          2:       value = skc_pkg::VAR_RESET;
          default: value = $urandom;
        endcase
        cfg_write(skc_pkg::REG_INITIAL_VARIANCE, value);
      end
      cfg_valid <= 1'b0;

      // Idling pattern cycles through none, sender only, receiver only, and both.
      case (ph % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 62;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 62;
        end
        default: begin
          gap_pct   = 33;
          stall_pct = 33;
        end
      endcase

      repeat (PHASE_SAMPLES) send_sample(next_sample(), gap_pct);
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
